// ----- hw/rtl/register_file_alu_with_flags_top_defines.svh -----
`ifndef REGISTER_FILE_ALU_WITH_FLAGS_TOP_DEFINES_SVH
`define REGISTER_FILE_ALU_WITH_FLAGS_TOP_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/rfalu_pkg.sv -----
`timescale 1ns / 1ps

package rfalu_pkg;

    localparam int NUM_REGS   = 8;
    localparam int DATA_WIDTH = 32;
    localparam int REG_IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int IDX_IN_W   = 3;
    localparam int SHAMT_W    = 5;
    localparam int PORT_W     = 32;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [REG_IDX_W-1:0]  reg_idx_t;

    typedef enum logic [3:0] {
        ACT_MOV = 4'd0,
        ACT_ADD = 4'd1,
        ACT_SUB = 4'd2,
        ACT_AND = 4'd3,
        ACT_ORR = 4'd4,
        ACT_NOT = 4'd5,
        ACT_XOR = 4'd6,
        ACT_LSR = 4'd7,
        ACT_LSL = 4'd8,
        ACT_CMP = 4'd9,
        ACT_TST = 4'd10
    } action_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    typedef struct packed {
        action_t              action;
        logic                 set_flags;
        reg_idx_t             dest;
        data_t                imm;
        logic [SHAMT_W-1:0]   shamt;
    } op_t;

    typedef struct packed {
        data_t  value;
        logic   wr;
        flags_t flags;
    } alu_res_t;

    // out-of-range index maps to the last register
    function automatic reg_idx_t sel_reg(input logic [IDX_IN_W-1:0] idx);
        reg_idx_t r;
        if (int'(idx) < NUM_REGS) begin
            r = reg_idx_t'(idx);
        end else begin
            r = reg_idx_t'(NUM_REGS - 1);
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/rfalu_regfile.sv -----
`timescale 1ns / 1ps

module rfalu_regfile import rfalu_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     rd_en,
    input  reg_idx_t rd_a_idx,
    input  reg_idx_t rd_b_idx,
    output data_t    rd_a_data,
    output data_t    rd_b_data,
    input  logic     wr_en,
    input  reg_idx_t wr_idx,
    input  data_t    wr_data
);

    data_t                mem [NUM_REGS];
    logic [NUM_REGS-1:0]  valid_reg;
    data_t                rd_a_reg;
    data_t                rd_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    // bypass a write landing on the same edge
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_idx == rd_a_idx)) begin
                rd_a_reg <= wr_data;
            end else if (valid_reg[rd_a_idx]) begin
                rd_a_reg <= mem[rd_a_idx];
            end else begin
                rd_a_reg <= '0;
            end
            if (wr_en && (wr_idx == rd_b_idx)) begin
                rd_b_reg <= wr_data;
            end else if (valid_reg[rd_b_idx]) begin
                rd_b_reg <= mem[rd_b_idx];
            end else begin
                rd_b_reg <= '0;
            end
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

// ----- hw/rtl/rfalu_alu.sv -----
`timescale 1ns / 1ps

module rfalu_alu import rfalu_pkg::*; (
    input  op_t      op,
    input  data_t    a,
    input  data_t    b,
    input  flags_t   flags_in,
    output alu_res_t res
);

    localparam int MSB = DATA_WIDTH - 1;

    logic [DATA_WIDTH:0] add_w;
    logic [DATA_WIDTH:0] sub_w;
    logic [DATA_WIDTH:0] lsr_w;
    logic [DATA_WIDTH:0] lsl_w;
    data_t               r;
    logic                wr;
    flags_t              f;

    function automatic flags_t set_nz(input flags_t fi, input data_t v);
        flags_t fo;
        fo   = fi;
        fo.n = v[MSB];
        fo.z = (v == '0);
        return fo;
    endfunction

    always_comb begin
        add_w = {1'b0, a} + {1'b0, b};
        sub_w = {1'b0, a} + {1'b0, ~b} + (DATA_WIDTH + 1)'(1);
        lsr_w = {a, 1'b0} >> op.shamt;
        lsl_w = {1'b0, a} << op.shamt;
        r     = '0;
        wr    = 1'b0;
        f     = flags_in;
        unique case (op.action)
            ACT_MOV: begin
                r  = op.imm;
                wr = 1'b1;
            end
            ACT_ADD: begin
                r  = add_w[MSB:0];
                wr = 1'b1;
                if (op.set_flags) begin
                    f   = set_nz(f, r);
                    f.c = add_w[DATA_WIDTH];
                    f.v = (a[MSB] ^ r[MSB]) & (b[MSB] ^ r[MSB]);
                end
            end
            ACT_SUB, ACT_CMP: begin
                r  = sub_w[MSB:0];
                wr = (op.action == ACT_SUB);
                if (op.set_flags || (op.action == ACT_CMP)) begin
                    f   = set_nz(f, r);
                    f.c = sub_w[DATA_WIDTH];
                    f.v = (a[MSB] ^ b[MSB]) & (a[MSB] ^ r[MSB]);
                end
            end
            ACT_AND, ACT_TST: begin
                r  = a & b;
                wr = (op.action == ACT_AND);
                if (op.set_flags || (op.action == ACT_TST)) begin
                    f = set_nz(f, r);
                end
            end
            ACT_ORR: begin
                r  = a | b;
                wr = 1'b1;
                if (op.set_flags) begin
                    f = set_nz(f, r);
                end
            end
            ACT_NOT: begin
                r  = ~a;
                wr = 1'b1;
                if (op.set_flags) begin
                    f = set_nz(f, r);
                end
            end
            ACT_XOR: begin
                r  = a ^ b;
                wr = 1'b1;
                if (op.set_flags) begin
                    f = set_nz(f, r);
                end
            end
            ACT_LSR: begin
                r  = lsr_w[DATA_WIDTH:1];
                wr = 1'b1;
                if (op.set_flags) begin
                    f = set_nz(f, r);
                    if (op.shamt != '0) begin
                        f.c = lsr_w[0];
                    end
                end
            end
            ACT_LSL: begin
                r  = lsl_w[MSB:0];
                wr = 1'b1;
                if (op.set_flags) begin
                    f = set_nz(f, r);
                    if (op.shamt != '0) begin
                        f.c = lsl_w[DATA_WIDTH];
                    end
                end
            end
            default: begin
                r  = '0;
                wr = 1'b0;
            end
        endcase
        res.value = r;
        res.wr    = wr;
        res.flags = f;
    end

endmodule

// ----- hw/rtl/register_file_alu_with_flags_top.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    action, set_flags, dest/src regs, immediate, shift
// m_        out        m_valid/m_ready    result_value, reg_written, flag_n/z/c/v
//
// One word per cycle while m_ready is high; m_valid rises once a word leaves the op stage.
// Register file reads are registered at accept, with write bypass for back-to-back words.
// Reset clears registers, flags and both pipeline stages.
// A stalled output holds the op stage; s_ready then follows m_ready.

module register_file_alu_with_flags_top import rfalu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_action,
    input  logic        s_set_flags,
    input  logic [2:0]  s_dest_reg,
    input  logic [2:0]  s_src_a_reg,
    input  logic [2:0]  s_src_b_reg,
    input  logic [31:0] s_immediate_value,
    input  logic [4:0]  s_shift_amount,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_value,
    output logic        m_reg_written,
    output logic        m_flag_n,
    output logic        m_flag_z,
    output logic        m_flag_c,
    output logic        m_flag_v
);

    op_t                op_reg;
    op_t                op_next;
    logic               op_valid_reg;
    logic               out_valid_reg;
    logic [PORT_W-1:0]  out_value_reg;
    logic               out_wr_reg;
    flags_t             out_flags_reg;
    flags_t             flags_reg;
    data_t              rd_a;
    data_t              rd_b;
    alu_res_t           alu_res;
    logic               advance;
    logic               accept;

    assign advance = op_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !op_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        op_next.action    = action_t'(s_action);
        op_next.set_flags = s_set_flags;
        op_next.dest      = sel_reg(s_dest_reg);
        op_next.imm       = data_t'(s_immediate_value);
        op_next.shamt     = s_shift_amount;
    end

    rfalu_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_a_idx  (sel_reg(s_src_a_reg)),
        .rd_b_idx  (sel_reg(s_src_b_reg)),
        .rd_a_data (rd_a),
        .rd_b_data (rd_b),
        .wr_en     (advance && alu_res.wr),
        .wr_idx    (op_reg.dest),
        .wr_data   (alu_res.value)
    );

    rfalu_alu u_alu (
        .op       (op_reg),
        .a        (rd_a),
        .b        (rd_b),
        .flags_in (flags_reg),
        .res      (alu_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (accept) begin
                op_valid_reg <= 1'b1;
            end else if (advance) begin
                op_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flags_reg     <= alu_res.flags;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= op_next;
        end
        if (advance) begin
            out_value_reg <= PORT_W'(alu_res.value);
            out_wr_reg    <= alu_res.wr;
            out_flags_reg <= alu_res.flags;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = out_value_reg;
    assign m_reg_written  = out_wr_reg;
    assign m_flag_n       = out_flags_reg.n;
    assign m_flag_z       = out_flags_reg.z;
    assign m_flag_c       = out_flags_reg.c;
    assign m_flag_v       = out_flags_reg.v;

endmodule

// ----- hw/rtl/rfalu_checker.sv -----
`timescale 1ns / 1ps
`include "register_file_alu_with_flags_top_defines.svh"

module rfalu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [3:0]  s_action,
    input logic        s_set_flags,
    input logic [2:0]  s_dest_reg,
    input logic [2:0]  s_src_a_reg,
    input logic [2:0]  s_src_b_reg,
    input logic [31:0] s_immediate_value,
    input logic [4:0]  s_shift_amount,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_result_value,
    input logic        m_reg_written,
    input logic        m_flag_n,
    input logic        m_flag_z,
    input logic        m_flag_c,
    input logic        m_flag_v
);

`ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready,
    m_valid && $stable(m_result_value) && $stable(m_reg_written)
    && $stable(m_flag_n) && $stable(m_flag_z) && $stable(m_flag_c) && $stable(m_flag_v))
`ASSERT_NEXT(a_s_hold, aclk, aresetn, s_valid && !s_ready,
    s_valid && $stable(s_action) && $stable(s_set_flags) && $stable(s_dest_reg)
    && $stable(s_src_a_reg) && $stable(s_src_b_reg) && $stable(s_immediate_value)
    && $stable(s_shift_amount))
`ASSERT_IMPL(a_z_not_n, aclk, aresetn, m_valid && m_flag_z, !m_flag_n)
`ASSERT_IMPL(a_cmp_tst_nz, aclk, aresetn,
    m_valid && !m_reg_written && (m_result_value != 32'd0),
    !m_flag_z && (m_flag_n == m_result_value[31]))

endmodule

bind register_file_alu_with_flags_top rfalu_checker u_rfalu_checker (.*);
